[rtl/core/poly_voice_allocator_top_assert.svh]
// Assertion macros shared by the voice allocator checkers.
// Needs nothing but a clock and an active-low reset at the point of use.
`ifndef POLY_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_TOP_ASSERT_SVH

// Check that cond implies prop in the same cycle.
`define PVA_ASSERT_SAME(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("voice allocator check failed");

// Check that cond implies prop in the next cycle.
`define PVA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("voice allocator check failed");

`endif

[rtl/core/pva_pkg.sv]
// Shared constants, types and the pitch function of the voice allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pva_pkg;

  localparam int VOICES     = 8;
  localparam int STAMP_BITS = 32;
  localparam int IDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int NOTE_W     = 7;
  localparam int VOICE_W    = 3;
  localparam int PITCH_W    = 16;

  // Middle C and the reciprocal of three for an 18-bit shift
  localparam logic signed [7:0] NOTE_CENTER = 8'sd60;
  localparam logic [16:0]       RECIP_3     = 17'd87382;
  localparam int                RECIP_SHIFT = 18;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ON   = 2'd1,
    CMD_OFF  = 2'd2
  } cmd_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  is_on;
    logic [NOTE_W-1:0]     note;
    logic [STAMP_BITS-1:0] best_stamp;
    logic [IDX_W-1:0]      best_idx;
    logic                  found;
    logic [IDX_W-1:0]      hit_idx;
  } tok_t;

  // Write broadcast to all cells
  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      idx;
    logic                  held;
    logic [NOTE_W-1:0]     note;
    logic [STAMP_BITS-1:0] stamp;
  } upd_t;

  // (note - 60) / 12 in Q.12, rounded to nearest: (|d| * 1024 + 1) / 3 with sign
  function automatic logic signed [PITCH_W-1:0] pitch_of(input logic [NOTE_W-1:0] note);
    logic signed [7:0]       d;
    logic [NOTE_W-1:0]       mag;
    logic [16:0]             x;
    logic [33:0]             prod;
    logic [PITCH_W-1:0]      q;
    d    = $signed({1'b0, note}) - NOTE_CENTER;
    mag  = d[7] ? 7'(-d) : d[6:0];
    x    = {mag, 10'b0} + 17'd1;
    prod = 34'(x) * 34'(RECIP_3);
    q    = prod[RECIP_SHIFT+PITCH_W-1:RECIP_SHIFT];
    return $signed(d[7] ? 16'(-q) : q);
  endfunction

endpackage

[rtl/core/pva_cell.sv]
// One voice cell: holds note, held flag and stamp, and refines the search token.
// Depends on pva_pkg for the token and write broadcast types.
`timescale 1ns / 1ps

module pva_cell import pva_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  tok_t             tok_in,
  input  upd_t             upd,
  output tok_t             tok_out
);

  logic [NOTE_W-1:0]     note_r;
  logic                  held_r;
  logic [STAMP_BITS-1:0] stamp_r;
  tok_t                  tok_r;
  tok_t                  tok_nxt;

  // Refine the token with this voice: oldest stamp for a request to start,
  // last held match for a release
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid) begin
      if (tok_in.is_on) begin
        if (stamp_r < tok_in.best_stamp) begin
          tok_nxt.best_stamp = stamp_r;
          tok_nxt.best_idx   = cell_idx;
        end
      end else if (held_r && (note_r == tok_in.note)) begin
        tok_nxt.found   = 1'b1;
        tok_nxt.hit_idx = cell_idx;
      end
    end
  end

  // Advance the token and take a write aimed at this voice
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_r  <= '0;
      held_r  <= 1'b0;
      stamp_r <= '0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (upd.en && (upd.idx == cell_idx)) begin
        note_r  <= upd.note;
        held_r  <= upd.held;
        stamp_r <= upd.stamp;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

[rtl/core/poly_voice_allocator_top.sv]
// Polyphonic voice allocator top: controller, sample clock and chain of voice cells.
// Depends on pva_pkg and pva_cell.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. The
//   command selects a sample tick, a note on or a note off (note on with zero
//   velocity counts as note off); command 3 is dropped.
//   A tick completes at once: busy stays low and the next request may follow
//   in the next cycle.
//   A note request launches a search token into the row of VOICES cells; it
//   moves one cell per cycle. In the cycle after it reaches the last cell's
//   output the result appears on the out_ ports with out_strobe high for one
//   cycle, and the chosen voice is written in the cycle after that. Busy stays
//   high from the accept until that write, so no request is taken meanwhile.
//   A note off with no held voice on that note gives no strobe.
//   The receiver cannot stall: each result is valid for its strobe cycle only.
//   Synchronous reset clears all voices, stamps and the sample counter; the
//   block is ready in the cycle after reset is released.
`timescale 1ns / 1ps

module poly_voice_allocator_top import pva_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_command,
  input  logic [NOTE_W-1:0]         in_note,
  input  logic [NOTE_W-1:0]         in_velocity,
  output logic                      out_strobe,
  output logic [VOICE_W-1:0]        out_voice,
  output logic [NOTE_W-1:0]         out_note_out,
  output logic                      out_gate,
  output logic signed [PITCH_W-1:0] out_pitch_cv
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [STAMP_BITS-1:0]      sample_time_r, sample_time_nxt;
  tok_t                       launch_r, launch_nxt;
  upd_t                       upd_r, upd_nxt;
  logic                       strobe_r, strobe_nxt;
  logic [VOICE_W-1:0]         voice_r, voice_nxt;
  logic [NOTE_W-1:0]          note_out_r, note_out_nxt;
  logic                       gate_r, gate_nxt;
  logic signed [PITCH_W-1:0]  pitch_r, pitch_nxt;

  tok_t                       chain [VOICES+1];
  tok_t                       last_tok;
  logic [IDX_W-1:0]           sel_idx;
  logic [IDX_W+VOICE_W-1:0]   sel_ext;

  // Row of voice cells
  assign chain[0] = launch_r;

  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    pva_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .tok_in   (chain[g]),
      .upd      (upd_r),
      .tok_out  (chain[g+1])
    );
  end

  assign last_tok = chain[VOICES];
  assign sel_idx  = last_tok.is_on ? last_tok.best_idx : last_tok.hit_idx;
  assign sel_ext  = {{VOICE_W{1'b0}}, sel_idx};

  // Sequence one request: count a tick, or launch, wait for the token, report, write
  always_comb begin
    state_nxt       = state_r;
    sample_time_nxt = sample_time_r;
    launch_nxt      = launch_r;
    launch_nxt.valid = 1'b0;
    upd_nxt         = upd_r;
    upd_nxt.en      = 1'b0;
    strobe_nxt      = 1'b0;
    voice_nxt       = voice_r;
    note_out_nxt    = note_out_r;
    gate_nxt        = gate_r;
    pitch_nxt       = pitch_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_command)
            CMD_TICK: begin
              sample_time_nxt = sample_time_r + 1'b1;
            end
            CMD_ON, CMD_OFF: begin
              launch_nxt.valid      = 1'b1;
              launch_nxt.is_on      = (in_command == CMD_ON) && (in_velocity != '0);
              launch_nxt.note       = in_note;
              launch_nxt.best_stamp = '1;
              launch_nxt.best_idx   = '0;
              launch_nxt.found      = 1'b0;
              launch_nxt.hit_idx    = '0;
              state_nxt             = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (last_tok.valid) begin
          upd_nxt.idx   = sel_idx;
          upd_nxt.held  = last_tok.is_on;
          upd_nxt.note  = last_tok.note;
          upd_nxt.stamp = sample_time_r;
          if (last_tok.is_on || last_tok.found) begin
            upd_nxt.en = 1'b1;
            strobe_nxt = 1'b1;
          end
          voice_nxt    = sel_ext[VOICE_W-1:0];
          note_out_nxt = last_tok.note;
          gate_nxt     = last_tok.is_on;
          pitch_nxt    = pitch_of(last_tok.note);
          state_nxt    = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      sample_time_r <= '0;
      launch_r      <= '0;
      upd_r         <= '0;
      strobe_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sample_time_r <= sample_time_nxt;
      launch_r      <= launch_nxt;
      upd_r         <= upd_nxt;
      strobe_r      <= strobe_nxt;
      voice_r       <= voice_nxt;
      note_out_r    <= note_out_nxt;
      gate_r        <= gate_nxt;
      pitch_r       <= pitch_nxt;
    end
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_strobe   = strobe_r;
  assign out_voice    = voice_r;
  assign out_note_out = note_out_r;
  assign out_gate     = gate_r;
  assign out_pitch_cv = pitch_r;

endmodule

[rtl/core/pva_checker.sv]
// Port-level checker for the voice allocator, bound to the top level.
// Depends on pva_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "poly_voice_allocator_top_assert.svh"

module pva_checker import pva_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_command,
  input logic       out_strobe
);

  logic req_take;
  logic req_note;

  // Decode an accepted request and whether it needs a scan
  assign req_take = start && !busy;
  assign req_note = (in_command == CMD_ON) || (in_command == CMD_OFF);

  // A result only appears while a note request is in progress
  `PVA_ASSERT_SAME(a_strobe_busy, clk, rst_n, out_strobe, busy)

  // A result is the last busy cycle and is never repeated
  `PVA_ASSERT_NEXT(a_strobe_end, clk, rst_n, out_strobe, !busy && !out_strobe)

  // Ticks and unused commands complete without going busy
  `PVA_ASSERT_NEXT(a_tick_free, clk, rst_n, req_take && !req_note, !busy)

  // A note request always starts a scan
  `PVA_ASSERT_NEXT(a_note_busy, clk, rst_n, req_take && req_note, busy)

endmodule

bind poly_voice_allocator_top pva_checker u_pva_checker (.*);

[tb/tb.sv]
// Self-checking bench for poly_voice_allocator_top: a directed table, then random note traffic.
// A local voice predictor supplies the expected voice changes. Needs pva_pkg and the RTL only.
`timescale 1ns / 1ps

module tb;
  import pva_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int IDLE_PCT      = 11;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int CALM_FIRST    = 700;   // random requests in [CALM_FIRST, CALM_LAST) never idle
  localparam int CALM_LAST     = 1100;
  localparam int DRAIN_CYCLES  = VOICES + 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PRINT_LIMIT   = 100;
  localparam int MIDDLE_C      = 60;

  // Command 3 has no member in cmd_t; the block drops it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [VOICE_W-1:0]        voice;
    logic [NOTE_W-1:0]         note;
    logic                      gate;
    logic signed [PITCH_W-1:0] pitch;
  } voice_change_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] vel;
    logic              typed;      // expected change written into the row
    logic              typed_hit;
    voice_change_t     typed_chg;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_command = CMD_TICK;
  logic [NOTE_W-1:0] in_note = '0;
  logic [NOTE_W-1:0] in_velocity = '0;
  logic busy;
  logic out_strobe;
  logic [VOICE_W-1:0] out_voice;
  logic [NOTE_W-1:0] out_note_out;
  logic out_gate;
  logic signed [PITCH_W-1:0] out_pitch_cv;

  // Voice predictor state
  logic [NOTE_W-1:0]     slot_note [VOICES];
  logic                  slot_held [VOICES];
  logic [STAMP_BITS-1:0] slot_stamp [VOICES];
  logic [STAMP_BITS-1:0] now_stamp;

  voice_change_t expected_changes [$];
  stim_row_t     directed_rows [$];
  int            mismatches = 0;
  int            cycle_count = 0;

  poly_voice_allocator_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_note      (in_note),
    .in_velocity  (in_velocity),
    .out_strobe   (out_strobe),
    .out_voice    (out_voice),
    .out_note_out (out_note_out),
    .out_gate     (out_gate),
    .out_pitch_cv (out_pitch_cv)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Count cycles for the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // (note - 60) / 12 octaves in Q.12: |d| * 1024 / 3 rounded to nearest, sign restored
  function automatic logic signed [PITCH_W-1:0] octave_cv(input logic [NOTE_W-1:0] note);
    int num;
    int q;
    num = (int'(note) - MIDDLE_C) * 1024;
    if (num >= 0) begin
      q = (num + 1) / 3;
    end else begin
      q = -((-num + 1) / 3);
    end
    return PITCH_W'(q);
  endfunction

  function automatic void clear_voices();
    int v;
    for (v = 0; v < VOICES; v++) begin
      slot_note[v]  = '0;
      slot_held[v]  = 1'b0;
      slot_stamp[v] = '0;
    end
    now_stamp = '0;
  endfunction

  // Advance the voice state by one accepted request; return 1 when it changes a voice
  function automatic bit apply_event(input logic [1:0] cmd, input logic [NOTE_W-1:0] note,
                                     input logic [NOTE_W-1:0] vel, output voice_change_t chg);
    int v;
    int pick;
    bit found;
    chg   = '0;
    pick  = 0;
    found = 1'b0;
    if (cmd == CMD_TICK) begin
      now_stamp = now_stamp + 1'b1;
      return 1'b0;
    end
    // Steal the voice with the smallest stamp, lowest index on a tie
    if (cmd == CMD_ON && vel != 0) begin
      for (v = 1; v < VOICES; v++) begin
        if (slot_stamp[v] < slot_stamp[pick]) pick = v;
      end
      slot_note[pick]  = note;
      slot_held[pick]  = 1'b1;
      slot_stamp[pick] = now_stamp;
      chg = '{VOICE_W'(pick), note, 1'b1, octave_cv(note)};
      return 1'b1;
    end
    // Release the highest-index held voice on this note, if any
    if (cmd == CMD_ON || cmd == CMD_OFF) begin
      for (v = 0; v < VOICES; v++) begin
        if (slot_held[v] && slot_note[v] == note) begin
          pick  = v;
          found = 1'b1;
        end
      end
      if (!found) return 1'b0;
      slot_held[pick]  = 1'b0;
      slot_stamp[pick] = now_stamp;
      chg = '{VOICE_W'(pick), note, 1'b0, octave_cv(note)};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic stim_row_t row(input logic [1:0] cmd, input int note, input int vel,
                                    input bit typed = 1'b0, input bit hit = 1'b0,
                                    input int voice = 0, input bit gate = 1'b0,
                                    input int pitch = 0);
    stim_row_t r;
    r.cmd       = cmd;
    r.note      = NOTE_W'(note);
    r.vel       = NOTE_W'(vel);
    r.typed     = typed;
    r.typed_hit = hit;
    r.typed_chg = '{VOICE_W'(voice), NOTE_W'(note), gate, PITCH_W'(pitch)};
    return r;
  endfunction

  // Mostly well-formed traffic: ticks, notes from a narrow pool, releases of held notes
  function automatic void pick_random_event(output logic [1:0] cmd,
                                            output logic [NOTE_W-1:0] note,
                                            output logic [NOTE_W-1:0] vel);
    logic [NOTE_W-1:0] held_notes [$];
    int roll;
    int v;
    roll = $urandom_range(99);
    note = NOTE_W'($urandom_range(127));
    vel  = NOTE_W'($urandom_range(127));
    for (v = 0; v < VOICES; v++) begin
      if (slot_held[v]) held_notes.push_back(slot_note[v]);
    end
    if (roll < 45) begin
      cmd = CMD_TICK;
    end else if (roll < 72) begin
      cmd = CMD_ON;
      if ($urandom_range(99) < 80) note = NOTE_W'($urandom_range(72, 48));
      vel = ($urandom_range(99) < 5) ? '0 : NOTE_W'($urandom_range(127, 1));
    end else if (roll < 97) begin
      cmd = CMD_OFF;
      // Use the zero-velocity note on as a release now and then
      if ($urandom_range(99) < 25) begin
        cmd = CMD_ON;
        vel = '0;
      end
      if (held_notes.size() != 0 && $urandom_range(99) < 85) begin
        note = held_notes[$urandom_range(held_notes.size() - 1)];
      end
    end else begin
      cmd = CMD_UNUSED;
    end
  endfunction

  // Present one request and hold it until accepted; with may_idle, start drops at random while waiting
  task automatic issue_request(input logic [1:0] cmd, input logic [NOTE_W-1:0] note,
                               input logic [NOTE_W-1:0] vel, input bit may_idle);
    bit idle;
    do begin
      idle = may_idle && ($urandom_range(99) < IDLE_PCT);
      start       <= !idle;
      in_command  <= cmd;
      in_note     <= note;
      in_velocity <= vel;
      @(posedge clk);
    end while (!(start && !busy));
  endtask

  // Compare every strobed change with the oldest expectation
  always @(posedge clk) begin : check_changes
    voice_change_t want;
    if (rst_n && out_strobe) begin
      if (expected_changes.size() == 0) begin
        report_mismatch($sformatf("change on voice %0d with nothing expected", out_voice));
      end else begin
        want = expected_changes.pop_front();
        if (out_voice !== want.voice)
          report_mismatch($sformatf("voice %0d, want %0d", out_voice, want.voice));
        if (out_note_out !== want.note)
          report_mismatch($sformatf("note %0d, want %0d", out_note_out, want.note));
        if (out_gate !== want.gate)
          report_mismatch($sformatf("gate %0b, want %0b", out_gate, want.gate));
        if (out_pitch_cv !== want.pitch)
          report_mismatch($sformatf("pitch %0d, want %0d", out_pitch_cv, want.pitch));
      end
    end
  end

  initial begin : stimulus
    stim_row_t         r;
    voice_change_t     chg;
    bit                hit;
    logic [1:0]        cmd;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] vel;
    int                sent;

    clear_voices();

    // Directed table: reset ties, extremes, silent cases, stealing, duplicate notes
    directed_rows.push_back(row(CMD_ON,     60, 127, 1, 1, 0, 1, 0));
    directed_rows.push_back(row(CMD_ON,    127,   1, 1, 1, 0, 1, 22869));
    directed_rows.push_back(row(CMD_OFF,   127,   0, 1, 1, 0, 0, 22869));
    directed_rows.push_back(row(CMD_OFF,   127, 127, 1, 0));
    directed_rows.push_back(row(CMD_UNUSED,127, 127, 1, 0));
    directed_rows.push_back(row(CMD_ON,      0,   0, 1, 0));
    directed_rows.push_back(row(CMD_TICK,    0,   0, 1, 0));
    directed_rows.push_back(row(CMD_ON,      0,  64, 1, 1, 0, 1, -20480));
    directed_rows.push_back(row(CMD_ON,     64, 127));
    directed_rows.push_back(row(CMD_ON,     64, 100));
    directed_rows.push_back(row(CMD_TICK,  127, 127));
    directed_rows.push_back(row(CMD_ON,     72,   1));
    directed_rows.push_back(row(CMD_ON,     48,   2));
    directed_rows.push_back(row(CMD_ON,    100,   3));
    directed_rows.push_back(row(CMD_ON,     36,   4));
    directed_rows.push_back(row(CMD_ON,     84,   5));
    directed_rows.push_back(row(CMD_ON,     90,   6));
    directed_rows.push_back(row(CMD_OFF,    64,  85));
    directed_rows.push_back(row(CMD_ON,     64,   0));
    directed_rows.push_back(row(CMD_OFF,    64,  42));
    directed_rows.push_back(row(CMD_TICK,   85,  42));
    directed_rows.push_back(row(CMD_ON,    127, 127));
    directed_rows.push_back(row(CMD_OFF,     0, 127));
    directed_rows.push_back(row(CMD_UNUSED,  0,   0));
    directed_rows.push_back(row(CMD_OFF,    36,  21));

    // Hold reset, then release it ahead of the first request
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      issue_request(r.cmd, r.note, r.vel, 1'b1);
      hit = apply_event(r.cmd, r.note, r.vel, chg);
      if (r.typed) begin
        hit = r.typed_hit;
        chg = r.typed_chg;
      end
      if (hit) expected_changes.push_back(chg);
    end

    // Random traffic; dropped commands do not count toward the total
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick_random_event(cmd, note, vel);
      issue_request(cmd, note, vel, !(sent >= CALM_FIRST && sent < CALM_LAST));
      if (apply_event(cmd, note, vel, chg)) expected_changes.push_back(chg);
      if (cmd != CMD_UNUSED) sent++;
    end
    start <= 1'b0;

    // Drain: wait for every expected change, then let a silent release finish
    while (expected_changes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/pva_pkg.sv
rtl/core/pva_cell.sv
rtl/core/poly_voice_allocator_top.sv
rtl/core/pva_checker.sv
tb/tb.sv
